// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define SCHV_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SCHV_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== sv/schv_pkg.sv =====
// Types, constants and the quantizer step table of the color histogram voter.
`timescale 1ns / 1ps

package schv_pkg;

  localparam int DIM_W       = 5;
  localparam int CHAN_W      = 8;
  localparam int INDEX_W     = 12;
  localparam int COUNT_OUT_W = 16;
  localparam int STEP_W      = 9;
  localparam int INC_W       = 3;

  localparam logic [DIM_W-1:0] DIM_RESET  = 5'd8;
  localparam logic [INC_W-1:0] INC_EDGE   = 3'd1;
  localparam logic [INC_W-1:0] INC_CENTER = 3'd6;  // one neighbor vote plus the bonus of 5

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUANT,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_BASE,
    ST_WALK,
    ST_DRAIN,
    ST_MOD,
    ST_READ,
    ST_FINISH
  } state_t;

  // floor(256 / d) for the bin count d
  function automatic logic [STEP_W-1:0] step_for_dim(input logic [DIM_W-1:0] d);
    logic [STEP_W-1:0] s;
    case (d) inside
      5'd0, 5'd1:        s = 9'd256;
      5'd2:              s = 9'd128;
      5'd3:              s = 9'd85;
      5'd4:              s = 9'd64;
      5'd5:              s = 9'd51;
      5'd6:              s = 9'd42;
      5'd7:              s = 9'd36;
      5'd8:              s = 9'd32;
      5'd9:              s = 9'd28;
      5'd10:             s = 9'd25;
      5'd11:             s = 9'd23;
      5'd12:             s = 9'd21;
      5'd13:             s = 9'd19;
      5'd14:             s = 9'd18;
      5'd15:             s = 9'd17;
      5'd16:             s = 9'd16;
      5'd17:             s = 9'd15;
      5'd18:             s = 9'd14;
      5'd19:             s = 9'd13;
      5'd20, 5'd21:      s = 9'd12;
      5'd22, 5'd23:      s = 9'd11;
      5'd24, 5'd25:      s = 9'd10;
      5'd26, 5'd27, 5'd28: s = 9'd9;
      default:           s = 9'd8;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/schv_divstep.sv =====
// Shared restoring-division step: shift in one dividend bit, compare, subtract.
`timescale 1ns / 1ps

module schv_divstep #(
  parameter int RW = 10
) (
  input  logic [RW-1:0] rem_in,
  input  logic          bit_in,
  input  logic [RW-1:0] divisor,
  output logic [RW-1:0] rem_out,
  output logic          q_out
);

  logic [RW-1:0] shifted;
  logic [RW:0]   diff;

  // rem_in is always below divisor, so its top bit is zero
  assign shifted = {rem_in[RW-2:0], bit_in};
  assign diff    = {1'b0, shifted} - {1'b0, divisor};
  assign q_out   = ~diff[RW];
  assign rem_out = q_out ? diff[RW-1:0] : shifted;

endmodule

// ===== sv/schv_bin_mem.sv =====
// Bin counter memory: one write port, one registered read port.
`timescale 1ns / 1ps

module schv_bin_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/soft_color_histogram_vote.sv =====
// Top level of the soft-binned 3-D color histogram voter.
`timescale 1ns / 1ps
//
// Channels: cfg (cfg_valid/cfg_ready/cfg_data) writes bins_per_channel and is
// always ready. Items come in on in_valid/in_ready, results leave on
// out_valid/out_ready, one result per item, in order.
// in_ready is high only while the sequencer is idle; an item is taken even
// while the previous result still sits unclaimed in the output register.
// Steps from acceptance to result in the output register:
//   accumulate: 3 x 8 divider steps on the shared step unit,
//     3 multiply steps, 1 address setup, 27 neighbor steps on the memory
//     read/write port pair, 1 write drain, 1 result load
//   read: 2 steps reducing the index modulo the store depth by a
//     reciprocal multiply, 1 memory read, 1 load
//   clear: one counter written per cycle over the whole store, then the load
//   unused action code: straight to the result load
// The next item can be accepted in the cycle after the result is loaded.
// Reset: a clearing pass writes zero to all MAX_BINS_PER_CHANNEL**3 counters,
// one per cycle; in_ready stays low meanwhile.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits at its last step until the register frees up.

module soft_color_histogram_vote #(
  parameter int MAX_BINS_PER_CHANNEL = 16,
  parameter int COUNT_WIDTH          = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [schv_pkg::DIM_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic [schv_pkg::CHAN_W-1:0]       chan0_value,
  input  logic [schv_pkg::CHAN_W-1:0]       chan1_value,
  input  logic [schv_pkg::CHAN_W-1:0]       chan2_value,
  input  logic [schv_pkg::INDEX_W-1:0]      bin_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              read_valid,
  output logic [schv_pkg::COUNT_OUT_W-1:0]  bin_count
);

  import schv_pkg::*;

  localparam int DEPTH   = MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL * MAX_BINS_PER_CHANNEL;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = (AW + 2 > STEP_W + 1) ? AW + 2 : STEP_W + 1;
  localparam int MW      = AW + DIM_W + 1;
  localparam int MAX_DIM = (MAX_BINS_PER_CHANNEL < 31) ? MAX_BINS_PER_CHANNEL : 31;

  // index / DEPTH as (index * RECIP) >> RECIP_SH, exact for every 12-bit index
  localparam int     RECIP_W  = INDEX_W + 2;
  localparam int     RECIP_SH = INDEX_W + $clog2(DEPTH);
  localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(DEPTH) - 1) /
                                longint'(DEPTH);

  localparam logic [DIM_W-1:0]   MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [RW-1:0]      DEPTH_V   = RW'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [1:0]         OFF_LAST  = 2'd2;
  localparam logic [2:0]         BIT_LAST_Q = 3'd7;
  localparam logic [3:0]         BIT_LAST_M = 4'd1;
  localparam logic [1:0]         CH_LAST   = 2'd2;

  state_t state, state_next;

  // configuration
  logic [DIM_W-1:0] dim_reg, dim_eff;

  // item registers
  action_t            act;
  logic [CHAN_W-1:0]  chan_a, chan_b, chan_c;
  logic [INDEX_W-1:0] idx_r;
  logic [INDEX_W-1:0] idx_q;
  logic [DIM_W-1:0]   dim;
  logic [STEP_W-1:0]  step_r;

  // divider
  logic [RW-1:0]      rem;
  logic [CHAN_W-1:0]  quo;
  logic [3:0]         bit_cnt;
  logic [1:0]         ch_cnt;
  logic [RW-1:0]      div_rem, div_divisor;
  logic               div_bit, div_q;
  logic [CHAN_W-1:0]  quo_full;
  logic [DIM_W-1:0]   q_a, q_b, q_c, q_new, dim_m1;
  logic [INDEX_W+RECIP_W-1:0] mod_prod;

  // address arithmetic
  logic [AW-1:0]      dd, prod, addr, d_row, d_plane;
  logic [AW-1:0]      mac_a;
  logic [DIM_W-1:0]   mac_b;
  logic [MW-1:0]      mac_full;
  logic [1:0]         oa, ob, oc;
  logic [DIM_W:0]     sa, sb, sc;
  logic               in_cube, center;

  // memory side
  logic               pend_valid;
  logic [AW-1:0]      pend_addr;
  logic [INC_W-1:0]   pend_inc;
  logic [AW-1:0]      clr_addr;
  logic               clr_reply;
  logic               mem_rd_en, mem_wr_en;
  logic [AW-1:0]      mem_rd_addr, mem_wr_addr;
  logic [COUNT_WIDTH-1:0] mem_rd_data, mem_wr_data;

  logic accept, out_free;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim_reg <= cfg_data;
    end
  end

  always_comb begin
    if (dim_reg == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_reg > MAX_DIM_V) begin
      dim_eff = MAX_DIM_V;
    end else begin
      dim_eff = dim_reg;
    end
  end

  schv_divstep #(.RW(RW)) u_divstep (
    .rem_in  (rem),
    .bit_in  (div_bit),
    .divisor (div_divisor),
    .rem_out (div_rem),
    .q_out   (div_q)
  );

  schv_bin_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COUNT_WIDTH)) u_bin_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // quantizer result with overflow clamp
  assign quo_full = {quo[CHAN_W-2:0], div_q};
  assign dim_m1   = dim - DIM_W'(1);
  assign q_new    = (quo_full > CHAN_W'(dim_m1)) ? dim_m1 : quo_full[DIM_W-1:0];

  // read index quotient by the store depth
  assign mod_prod = (INDEX_W + RECIP_W)'(idx_r) * (INDEX_W + RECIP_W)'(RECIP_V);

  // one multiplier for the address steps, always by the current bin count
  assign mac_full = MW'(mac_a) * MW'(dim) + MW'(mac_b);

  // neighbor coordinates are q + offset - 1; in range means 1 <= q + offset <= dim
  assign sa      = {1'b0, q_a} + (DIM_W + 1)'(oa);
  assign sb      = {1'b0, q_b} + (DIM_W + 1)'(ob);
  assign sc      = {1'b0, q_c} + (DIM_W + 1)'(oc);
  assign in_cube = (sa != '0) && (sa <= {1'b0, dim}) &&
                   (sb != '0) && (sb <= {1'b0, dim}) &&
                   (sc != '0) && (sc <= {1'b0, dim});
  assign center  = (oa == 2'd1) && (ob == 2'd1) && (oc == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_ACCUM: state_next = ST_QUANT;
            ACT_READ:  state_next = ST_MOD;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_QUANT: begin
        if (bit_cnt[2:0] == BIT_LAST_Q && ch_cnt == CH_LAST) begin
          state_next = ST_MAC0;
        end
      end
      ST_MAC0:  state_next = ST_MAC1;
      ST_MAC1:  state_next = ST_MAC2;
      ST_MAC2:  state_next = ST_BASE;
      ST_BASE:  state_next = ST_WALK;
      ST_WALK: begin
        if (oa == OFF_LAST && ob == OFF_LAST && oc == OFF_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_MOD: begin
        if (bit_cnt == BIT_LAST_M) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    div_bit     = chan_a[CHAN_W-1];
    div_divisor = RW'(step_r);
    mac_a       = prod;
    mac_b       = q_c;
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr;
    mem_wr_en   = pend_valid;
    mem_wr_addr = pend_addr;
    mem_wr_data = mem_rd_data + COUNT_WIDTH'(pend_inc);
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      ST_MAC0: begin
        mac_a = AW'(dim);
        mac_b = '0;
      end
      ST_MAC1: begin
        mac_a = AW'(q_a);
        mac_b = q_b;
      end
      ST_WALK:  mem_rd_en = in_cube;
      ST_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rem[AW-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == ST_WALK) && in_cube;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else if (accept) begin
        clr_addr  <= '0;
        clr_reply <= (action_t'(action) == ACT_CLEAR);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pend_addr <= addr;
    pend_inc  <= center ? INC_CENTER : INC_EDGE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          act     <= action_t'(action);
          chan_a  <= chan0_value;
          chan_b  <= chan1_value;
          chan_c  <= chan2_value;
          idx_r   <= bin_index;
          dim     <= dim_eff;
          step_r  <= step_for_dim(dim_eff);
          rem     <= '0;
          bit_cnt <= '0;
          ch_cnt  <= '0;
        end
      end
      ST_QUANT: begin
        quo     <= quo_full;
        bit_cnt <= bit_cnt + 4'd1;
        rem     <= div_rem;
        chan_a  <= chan_a << 1;
        if (bit_cnt[2:0] == BIT_LAST_Q) begin
          // channel done: shift the clamped bin into the q registers
          rem     <= '0;
          bit_cnt <= '0;
          ch_cnt  <= ch_cnt + 2'd1;
          q_c     <= q_new;
          q_b     <= q_c;
          q_a     <= q_b;
          chan_a  <= chan_b;
          chan_b  <= chan_c;
        end
      end
      ST_MAC0:  dd   <= mac_full[AW-1:0];
      ST_MAC1:  prod <= mac_full[AW-1:0];
      ST_MAC2:  prod <= mac_full[AW-1:0];
      ST_BASE: begin
        // start at the (-1,-1,-1) corner; arithmetic is modulo 2^AW
        addr    <= prod - dd - AW'(dim) - AW'(1);
        d_row   <= AW'(dim) - AW'(2);
        d_plane <= dd - (AW'(dim) << 1) - AW'(2);
        oa      <= '0;
        ob      <= '0;
        oc      <= '0;
      end
      ST_WALK: begin
        if (oc != OFF_LAST) begin
          oc   <= oc + 2'd1;
          addr <= addr + AW'(1);
        end else if (ob != OFF_LAST) begin
          oc   <= '0;
          ob   <= ob + 2'd1;
          addr <= addr + d_row;
        end else begin
          oc   <= '0;
          ob   <= '0;
          oa   <= oa + 2'd1;
          addr <= addr + d_plane;
        end
      end
      ST_MOD: begin
        bit_cnt <= bit_cnt + 4'd1;
        // first the quotient, then the remainder from it
        if (bit_cnt == BIT_LAST_M) begin
          rem <= RW'(idx_r) - RW'(idx_q) * DEPTH_V;
        end else begin
          idx_q <= INDEX_W'(mod_prod >> RECIP_SH);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      read_valid <= (act == ACT_READ);
      bin_count  <= (act == ACT_READ) ? COUNT_OUT_W'(mem_rd_data) : '0;
    end
  end

endmodule

// ===== sv/schv_checker.sv =====
// Port-level checks for the color histogram voter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module schv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             read_valid,
  input logic [schv_pkg::COUNT_OUT_W-1:0] bin_count
);

  import schv_pkg::*;

  // a stalled result must not move
  `SCHV_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(bin_count) && $stable(read_valid), "result changed while stalled")

  // only a read carries a count
  `SCHV_ASSERT(a_count_on_read, clk, rst, out_valid && !read_valid |-> bin_count == '0, "nonzero count on a non-read result")

  // in_ready is low in the cycle after an accepted item
  `SCHV_ASSERT(a_busy_after_item, clk, rst, in_valid && in_ready |=> !in_ready, "ready right after an accepted item")

  // reset starts the clearing pass with no result pending
  `SCHV_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid && !in_ready, "not quiet after reset")

endmodule

bind soft_color_histogram_vote schv_checker u_schv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_valid (read_valid),
  .bin_count  (bin_count)
);
